FILE: sv/utf8_stream_decoder_unit_assert.svh
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/utf8d_pkg.sv
// Types and constants shared by the UTF-8 stream decoder modules.
package utf8d_pkg;

    localparam int CP_W      = 21;
    localparam int RBUF_DEPTH = 4;
    localparam int RBUF_AW   = $clog2(RBUF_DEPTH);
    localparam int RBUF_LW   = $clog2(RBUF_DEPTH + 1);

    // lowest code point allowed for each sequence length (overlong check)
    localparam logic [CP_W-1:0] MIN_CP_TWO   = 21'h00080;
    localparam logic [CP_W-1:0] MIN_CP_THREE = 21'h00800;
    localparam logic [CP_W-1:0] MIN_CP_FOUR  = 21'h10000;

    localparam logic [7:0] LEAD_BAD_HI  = 8'hC1;
    localparam logic [7:0] LEAD_TWO_HI  = 8'hDF;
    localparam logic [7:0] LEAD_THREE_HI = 8'hEF;
    localparam logic [7:0] LEAD_FOUR_HI = 8'hF4;

    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_SKIP    = 2'd2
    } mode_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            is_end;
        logic            string_valid;
        logic            last_of_item;
    } result_t;

    // results produced by one byte: count 0..2, first then second
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } core_out_t;

    typedef struct packed {
        logic               room;
        logic [RBUF_LW-1:0] level;
    } rbuf_stat_t;

endpackage

FILE: sv/utf8d_core.sv
// Decoder state and the per-byte decode logic.
module utf8d_core
    import utf8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic [7:0] data_byte,
    output core_out_t res
);

    mode_t           mode_reg,  mode_next;
    logic [CP_W-1:0] pv_reg,    pv_next;
    logic [1:0]      tl_reg,    tl_next;
    logic [1:0]      sl_reg,    sl_next;
    logic            nes_reg,   nes_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pv_reg   <= '0;
            tl_reg   <= '0;
            sl_reg   <= '0;
            nes_reg  <= 1'b1;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pv_reg   <= pv_next;
            tl_reg   <= tl_next;
            sl_reg   <= sl_next;
            nes_reg  <= nes_next;
        end
    end

    always_comb
    begin
        logic            trail;
        logic            do_fresh;
        logic            fres_v;
        result_t         fres;
        logic [CP_W-1:0] shifted;
        logic [CP_W-1:0] minc;
        logic [1:0]      tl_dec;

        trail     = (data_byte[7:6] == 2'b10);
        do_fresh  = 1'b0;
        fres_v    = 1'b0;
        fres      = '0;
        shifted   = {pv_reg[CP_W-7:0], data_byte[5:0]};
        tl_dec    = tl_reg - 2'd1;
        minc      = MIN_CP_FOUR;
        mode_next = mode_reg;
        pv_next   = pv_reg;
        tl_next   = tl_reg;
        sl_next   = sl_reg;
        nes_next  = nes_reg;
        res       = '0;

        case (mode_reg)
            MODE_COLLECT:
            begin
                if (trail)
                begin
                    pv_next = shifted;
                    tl_next = tl_dec;
                    if (tl_dec == 2'd0)
                    begin
                        case (sl_reg)
                            SEQ_TWO:   minc = MIN_CP_TWO;
                            SEQ_THREE: minc = MIN_CP_THREE;
                            default:   minc = MIN_CP_FOUR;
                        endcase
                        res.cnt = 2'd1;
                        if (shifted < minc)
                        begin
                            mode_next          = MODE_SKIP;
                            nes_next           = 1'b0;
                            res.first.is_error = 1'b1;
                        end
                        else
                        begin
                            mode_next            = MODE_IDLE;
                            res.first.code_point = shifted;
                        end
                    end
                end
                else
                begin
                    // sequence broken: report it, then treat the byte afresh
                    res.cnt            = 2'd1;
                    res.first.is_error = 1'b1;
                    nes_next           = 1'b0;
                    mode_next          = MODE_IDLE;
                    do_fresh           = 1'b1;
                end
            end
            MODE_SKIP:
            begin
                do_fresh = !trail;
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        if (do_fresh)
        begin
            if (data_byte == 8'd0)
            begin
                fres_v            = 1'b1;
                fres.is_end       = 1'b1;
                fres.string_valid = nes_next;
                mode_next         = MODE_IDLE;
                nes_next          = 1'b1;
            end
            else if (!data_byte[7])
            begin
                fres_v          = 1'b1;
                fres.code_point = {{(CP_W-8){1'b0}}, data_byte};
                mode_next       = MODE_IDLE;
            end
            else if (data_byte <= LEAD_BAD_HI || data_byte > LEAD_FOUR_HI)
            begin
                fres_v        = 1'b1;
                fres.is_error = 1'b1;
                mode_next     = MODE_SKIP;
                nes_next      = 1'b0;
            end
            else
            begin
                if (data_byte <= LEAD_TWO_HI)
                begin
                    pv_next = {{(CP_W-5){1'b0}}, data_byte[4:0]};
                    sl_next = SEQ_TWO;
                end
                else if (data_byte <= LEAD_THREE_HI)
                begin
                    pv_next = {{(CP_W-4){1'b0}}, data_byte[3:0]};
                    sl_next = SEQ_THREE;
                end
                else
                begin
                    pv_next = {{(CP_W-3){1'b0}}, data_byte[2:0]};
                    sl_next = SEQ_FOUR;
                end
                tl_next   = sl_next;
                mode_next = MODE_COLLECT;
            end
        end

        if (fres_v)
        begin
            if (res.cnt == 2'd0)
            begin
                res.first = fres;
                res.cnt   = 2'd1;
            end
            else
            begin
                res.second = fres;
                res.cnt    = 2'd2;
            end
        end

        if (res.cnt == 2'd1)
            res.first.last_of_item = 1'b1;
        else if (res.cnt == 2'd2)
            res.second.last_of_item = 1'b1;

        if (!step)
            res.cnt = 2'd0;
    end

endmodule

FILE: sv/utf8d_rbuf.sv
// Small result queue: takes up to two results a cycle, gives one.
module utf8d_rbuf
    import utf8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  core_out_t  push,
    input  logic       pop,
    output result_t    head,
    output logic       head_valid,
    output rbuf_stat_t stat
);

    result_t            mem [RBUF_DEPTH];
    logic [RBUF_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RBUF_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RBUF_LW-1:0] level_reg,  level_next;
    logic               pop_ok;

    assign head_valid = (level_reg != '0);
    assign pop_ok     = pop && head_valid;
    assign head       = mem[rd_ptr_reg];
    assign stat.level = level_reg;
    // a byte may bring two results
    assign stat.room  = (level_reg <= RBUF_LW'(RBUF_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RBUF_AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + RBUF_AW'(pop_ok);
        level_next  = level_reg + RBUF_LW'(push.cnt) - RBUF_LW'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RBUF_DEPTH; i++)
        begin
            if (push.cnt != 2'd0 && RBUF_AW'(i) == wr_ptr_reg)
                mem[i] <= push.first;
            if (push.cnt == 2'd2 && RBUF_AW'(i) == RBUF_AW'(wr_ptr_reg + RBUF_AW'(1)))
                mem[i] <= push.second;
        end
    end

endmodule

FILE: sv/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder.
//
// Streaming UTF-8 decoder. Each input word carries one byte of a zero-terminated
// string; each output word carries one result. ASCII bytes come straight out as
// code points; a lead byte (C2-DF, E0-EF, F0-F4) opens a 2-, 3- or 4-byte
// sequence whose code point appears with its last continuation byte. Invalid
// leads, stray continuation bytes and overlong forms give an error word (code
// point zero), after which continuation bytes are dropped quietly. A missing
// continuation byte gives an error word and the interrupting byte is then
// decoded as usual, so one input byte yields at most two output words; tlast
// marks the final word caused by a byte. A zero byte gives an end word whose
// string_valid bit says whether the string was error-free, and starts a new
// string. Surrogates and values above 10FFFF are passed unchecked.
// Timing: one input byte per cycle sustained. A taken byte is held in the input
// register, which feeds the decode logic and a four-entry result queue; the
// decoded results are written into the queue, whose head drives the output.
// A byte is decoded once the queue has room for two results, so rate drops
// only while the sink stalls or while double-result bytes outpace a
// one-word-per-cycle output.
module utf8_stream_decoder_unit
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [2:0]  m_axis_tuser,   // [0] is_error, [1] is_end, [2] string_valid
    output logic        m_axis_tlast    // last_of_item
);

    `include "utf8_stream_decoder_unit_assert.svh"

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       step;
    core_out_t  core_res;
    result_t    head;
    logic       head_valid;
    rbuf_stat_t rb_stat;

    // decode the held byte when the queue can absorb both possible results
    assign step          = in_valid_reg && rb_stat.room;
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    utf8d_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .res       (core_res)
    );

    utf8d_rbuf u_rbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (core_res),
        .pop        (m_axis_tready),
        .head       (head),
        .head_valid (head_valid),
        .stat       (rb_stat)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = {{(24-CP_W){1'b0}}, head.code_point};
    assign m_axis_tuser  = {head.string_valid, head.is_end, head.is_error};
    assign m_axis_tlast  = head.last_of_item;

    // queue never overfills
    `UTF8D_ASSERT_NOW(a_level_bound, 1'b1, rb_stat.level <= RBUF_LW'(RBUF_DEPTH), "result queue overflow")
    // a byte only yields two results when the first reports a broken sequence
    `UTF8D_ASSERT_NOW(a_pair_err, core_res.cnt == 2'd2, core_res.first.is_error && !core_res.first.last_of_item, "bad result pair")
    // end and error words carry no code point
    `UTF8D_ASSERT_NOW(a_flag_cp, m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]), m_axis_tdata == 24'd0, "code point on flag word")
    // an empty queue with nothing pushed shows no word next cycle
    `UTF8D_ASSERT_NEXT(a_empty, rb_stat.level == '0 && core_res.cnt == 2'd0, !m_axis_tvalid, "word from empty queue")

endmodule

FILE: tb/sv/utf8_stream_decoder_unit_tb.sv
// Self-checking testbench for the UTF-8 stream decoder top level.
module utf8_stream_decoder_unit_tb;
    import utf8d_pkg::*;

    localparam int RANDOM_BYTES = 1420;   // random part stops once this many bytes went in
    localparam int PHASE_BYTES  = 240;    // pacing changes every this many bytes

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [20:0] code_point, [23:21] zero
    logic [2:0]  m_axis_tuser;            // [0] is_error, [1] is_end, [2] string_valid
    logic        m_axis_tlast;            // last_of_item

    // decoder state as this side sees it
    mode_t           dec_mode = MODE_IDLE;
    logic [CP_W-1:0] acc_value = '0;
    logic [1:0]      trails_due = 2'd0;
    logic [1:0]      seq_len = 2'd0;
    logic            string_clean = 1'b1;

    result_t     expected_words[$];
    int unsigned mismatches = 0;
    int unsigned sent_bytes = 0;

    // sender pacing: bursts of 1..16 words, then, if gap_max is nonzero, a random gap with valid low
    int unsigned burst_left = 0;
    int unsigned gap_max = 0;

    // sink pacing: a fresh random stall pattern each time pace_tick wraps, density set by stall_level
    int unsigned stall_level = 0;         // 0 never, 1 ~25 %, 2 ~50 %, 3 ~75 %
    logic [31:0] stall_bits = '0;
    logic [4:0]  pace_tick = '0;

    utf8_stream_decoder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sink side: tready follows the current pattern, refreshed whenever pace_tick wraps to zero.
    always @(negedge clk)
    begin : sink_pace
        if (pace_tick == 5'd0)
        begin
            case (stall_level)
                0:       stall_bits = '0;
                1:       stall_bits = $urandom() & $urandom();
                2:       stall_bits = $urandom();
                default: stall_bits = $urandom() | $urandom();
            endcase
        end
        m_axis_tready = !stall_bits[pace_tick];
        pace_tick     = pace_tick + 5'd1;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void push_word(input logic [CP_W-1:0] cp, input logic err,
                                      input logic fin, input logic ok);
        result_t w;
        w.code_point   = cp;
        w.is_error     = err;
        w.is_end       = fin;
        w.string_valid = ok;
        w.last_of_item = 1'b0;
        if (err)
            string_clean = 1'b0;
        expected_words.push_back(w);
    endfunction

    // A byte not taken as a continuation: end, ASCII, bad lead or new lead.
    function automatic void take_fresh(input logic [7:0] b);
        if (b == 8'h00)
        begin
            push_word('0, 1'b0, 1'b1, string_clean);
            dec_mode     = MODE_IDLE;
            string_clean = 1'b1;
        end
        else if (b < 8'h80)
        begin
            dec_mode = MODE_IDLE;
            push_word({13'd0, b}, 1'b0, 1'b0, 1'b0);
        end
        else if (b <= LEAD_BAD_HI || b > LEAD_FOUR_HI)
        begin
            // stray continuation, C0/C1 or F5-FF
            dec_mode = MODE_SKIP;
            push_word('0, 1'b1, 1'b0, 1'b0);
        end
        else
        begin
            if (b <= LEAD_TWO_HI)
            begin
                acc_value = {16'd0, b[4:0]};
                seq_len   = SEQ_TWO;
            end
            else if (b <= LEAD_THREE_HI)
            begin
                acc_value = {17'd0, b[3:0]};
                seq_len   = SEQ_THREE;
            end
            else
            begin
                acc_value = {18'd0, b[2:0]};
                seq_len   = SEQ_FOUR;
            end
            trails_due = seq_len;
            dec_mode   = MODE_COLLECT;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int unsigned     prior_cnt;
        logic [CP_W-1:0] floor_cp;
        prior_cnt = expected_words.size();
        if (dec_mode == MODE_COLLECT)
        begin
            if (b[7:6] == 2'b10)
            begin
                acc_value  = {acc_value[CP_W-7:0], b[5:0]};
                trails_due = trails_due - 2'd1;
                if (trails_due == 2'd0)
                begin
                    floor_cp = (seq_len == SEQ_TWO)   ? MIN_CP_TWO :
                               (seq_len == SEQ_THREE) ? MIN_CP_THREE : MIN_CP_FOUR;
                    if (acc_value < floor_cp)
                    begin
                        // overlong form
                        dec_mode = MODE_SKIP;
                        push_word('0, 1'b1, 1'b0, 1'b0);
                    end
                    else
                    begin
                        dec_mode = MODE_IDLE;
                        push_word(acc_value, 1'b0, 1'b0, 1'b0);
                    end
                end
            end
            else
            begin
                // sequence cut short; the interrupting byte is decoded afresh
                push_word('0, 1'b1, 1'b0, 1'b0);
                dec_mode = MODE_IDLE;
                take_fresh(b);
            end
        end
        else if (!(dec_mode == MODE_SKIP && b[7:6] == 2'b10))
            take_fresh(b);
        if (expected_words.size() > prior_cnt)
            expected_words[expected_words.size() - 1].last_of_item = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void flag_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
                flag_mismatch("unexpected word (tdata)", 0, m_axis_tdata);
            else
            begin
                want = expected_words.pop_front();
                if (m_axis_tdata !== {3'b000, want.code_point})
                    flag_mismatch("code_point", want.code_point, m_axis_tdata);
                if (m_axis_tuser[0] !== want.is_error)
                    flag_mismatch("is_error", want.is_error, m_axis_tuser[0]);
                if (m_axis_tuser[1] !== want.is_end)
                    flag_mismatch("is_end", want.is_end, m_axis_tuser[1]);
                if (m_axis_tuser[2] !== want.string_valid)
                    flag_mismatch("string_valid", want.string_valid, m_axis_tuser[2]);
                if (m_axis_tlast !== want.last_of_item)
                    flag_mismatch("last_of_item", want.last_of_item, m_axis_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one word; valid stays high into the next call unless a gap is due.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gap_max != 0)
            begin
                gap = $urandom_range(1, gap_max);
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_byte(b);
        sent_bytes++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_list(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Encode cp in len bytes (overlong if cp is small) and send the first n of them.
    task automatic send_cp(input int unsigned cp, input int unsigned len, input int unsigned n);
        logic [7:0] enc[4];
        logic [20:0] v;
        v = cp[20:0];
        case (len)
            1: enc[0] = {1'b0, v[6:0]};
            2:
            begin
                enc[0] = {3'b110, v[10:6]};
                enc[1] = {2'b10, v[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, v[15:12]};
                enc[1] = {2'b10, v[11:6]};
                enc[2] = {2'b10, v[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, v[20:18]};
                enc[1] = {2'b10, v[17:12]};
                enc[2] = {2'b10, v[11:6]};
                enc[3] = {2'b10, v[5:0]};
            end
        endcase
        for (int i = 0; i < n; i++)
            send_byte(enc[i]);
    endtask

    task automatic test_ascii_and_end();
        gap_max     = 0;
        stall_level = 0;
        send_list('{8'h01, 8'h7F, 8'h00});
    endtask

    // shortest and longest two-byte forms, shortest three-byte form; F4 BF BF BF lies above 10FFFF, passed unchecked
    task automatic test_multibyte();
        gap_max     = 2;
        stall_level = 1;
        send_list('{8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
                    8'hF4, 8'hBF, 8'hBF, 8'hBF});
    endtask

    // stray continuation in idle, C0 with its continuation skipped, F5 then ASCII
    task automatic test_bad_leads();
        stall_level = 3;
        send_list('{8'hBF, 8'hC0, 8'h80, 8'hF5, 8'h41});
    endtask

    // overlong, cut short by ASCII, cut short by a bad lead, then a tainted end
    task automatic test_broken_sequences();
        gap_max     = 0;
        stall_level = 2;
        send_list('{8'hE0, 8'h80, 8'h80, 8'hC2, 8'h41, 8'hE1, 8'hFF, 8'h00});
    endtask

    function automatic int unsigned cp_for_length(input int unsigned len);
        case (len)
            1:       return $urandom_range(32'h1, 32'h7F);
            2:       return $urandom_range(32'h80, 32'h7FF);
            3:       return $urandom_range(32'h800, 32'hFFFF);
            default: return $urandom_range(32'h10000, 32'h13FFFF);
        endcase
    endfunction

    // Mostly well-formed strings with random content, some noise, cuts and overlongs.
    task automatic test_random_strings();
        int unsigned stop_at;
        int unsigned next_phase;
        int unsigned chars;
        int unsigned pick;
        int unsigned len;
        stop_at    = sent_bytes + RANDOM_BYTES;
        next_phase = sent_bytes;
        while (sent_bytes < stop_at)
        begin
            if (sent_bytes >= next_phase)
            begin
                next_phase  = sent_bytes + PHASE_BYTES;
                gap_max     = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                stall_level = $urandom_range(0, 3);
            end
            chars = $urandom_range(0, 12);
            repeat (chars)
            begin
                pick = $urandom_range(0, 99);
                len  = $urandom_range(1, 4);
                if (pick < 78)
                    send_cp(cp_for_length(len), len, len);
                else if (pick < 86)
                    send_byte(8'($urandom_range(1, 255)));
                else if (pick < 94)
                begin
                    if (len == 1)
                        len = 2;
                    send_cp(cp_for_length(len), len, $urandom_range(1, len - 1));
                end
                else
                begin
                    // value small enough for a shorter form
                    len = $urandom_range(2, 4);
                    send_cp(cp_for_length(len - 1) >> $urandom_range(0, 4), len, len);
                end
            end
            // now and then strings run on without a terminator
            if ($urandom_range(0, 19) != 0)
                send_byte(8'h00);
        end
    endtask

    initial
    begin : run
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ascii_and_end();
        test_multibyte();
        test_bad_leads();
        test_broken_sequences();
        test_random_strings();

        s_axis_tvalid = 1'b0;
        stall_level   = 0;
        while (expected_words.size() != 0)
            @(posedge clk);
        // keep clocking to catch any word beyond the predicted ones
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: utf8_stream_decoder_unit.f
+incdir+sv
sv/utf8d_pkg.sv
sv/utf8d_core.sv
sv/utf8d_rbuf.sv
sv/utf8_stream_decoder_unit.sv
tb/sv/utf8_stream_decoder_unit_tb.sv
